// File: design/brpi_pkg.sv
// Package with shared constants and types for the box/ray/point intersection tester.
package brpi_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int CFG_IDX_BITS   = 3;
    localparam int T_BITS         = 32;
    localparam int Q_FRAC         = 16;
    localparam int Q_INT          = 15;

    typedef enum logic [1:0] {
        REQ_BOX     = 2'd0,
        REQ_SEGMENT = 2'd1,
        REQ_POINT   = 2'd2,
        REQ_RAYRAY  = 2'd3
    } req_type_t;

    typedef enum logic [2:0] {
        REG_LO_X = 3'd0,
        REG_LO_Y = 3'd1,
        REG_LO_Z = 3'd2,
        REG_HI_X = 3'd3,
        REG_HI_Y = 3'd4,
        REG_HI_Z = 3'd5
    } reg_idx_t;

    // Per-axis status from the first stage to the combining stage.
    typedef struct packed {
        logic zero_dir;
        logic in_slab;
    } axis_flags_t;

endpackage

// File: design/brpi_slab_div.sv
// Pipelined restoring divider producing a saturated signed Q15.16 slab parameter.
module brpi_slab_div
    import brpi_pkg::*;
#(
    parameter int W = COORD_BITS_DEF + 1
)
(
    input  logic                    clk,
    input  logic signed [W:0]       num,
    input  logic signed [W:0]       den,
    output logic signed [T_BITS:0]  quo
);

    // One quotient bit per stage: Q_INT+1 overflow-guard/integer bits and Q_FRAC fraction bits.
    localparam int NB = Q_INT + 1 + Q_FRAC;
    localparam int RW = W + 2;

    logic [RW-1:0] rem_reg  [0:NB];
    logic [RW-1:0] d_reg    [0:NB];
    logic [NB-1:0] q_reg    [0:NB];
    logic          neg_reg  [0:NB];
    logic          ovf_reg  [0:NB];
    logic [W:0]    n_hi_reg [0:NB];

    logic [W:0] n_abs;
    logic [W:0] d_abs;

    assign n_abs = num[W] ? (W+1)'(0) - num : num;
    assign d_abs = den[W] ? (W+1)'(0) - den : den;

    // Integer bits above 2^15 are checked by comparing n against d << 15 in stage 0.
    // The dividend is n << 16; its bits above the 32 quotient positions seed the
    // remainder, and the low 16 bits of n are shifted in from the top of n_hi_reg.
    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= RW'(n_abs >> (Q_INT + 1));
        d_reg[0]    <= RW'(d_abs);
        q_reg[0]    <= '0;
        neg_reg[0]  <= num[W] ^ den[W];
        ovf_reg[0]  <= ({2'b0, n_abs} >> Q_INT) >= {1'b0, d_abs};
        n_hi_reg[0] <= n_abs << (W - Q_INT);
    end

    for (genvar s = 0; s < NB; s++) begin : g_stage
        logic [RW-1:0] trial;
        logic [RW-1:0] shifted;
        logic          nbit;
        always_comb
        begin
            // Numerator bits arrive at the top of n_hi_reg, zeros once they run out.
            nbit    = n_hi_reg[s][W];
            shifted = {rem_reg[s][RW-2:0], nbit};
            trial   = shifted - d_reg[s];
        end
        always_ff @(posedge clk)
        begin
            if (shifted >= d_reg[s]) begin
                rem_reg[s+1] <= trial;
                q_reg[s+1]   <= {q_reg[s][NB-2:0], 1'b1};
            end else begin
                rem_reg[s+1] <= shifted;
                q_reg[s+1]   <= {q_reg[s][NB-2:0], 1'b0};
            end
            d_reg[s+1]    <= d_reg[s];
            neg_reg[s+1]  <= neg_reg[s];
            ovf_reg[s+1]  <= ovf_reg[s];
            n_hi_reg[s+1] <= n_hi_reg[s] << 1;
        end
    end

    logic [T_BITS-1:0] mag;
    always_comb
    begin
        mag = ovf_reg[NB] ? {1'b0, {(T_BITS-1){1'b1}}} : T_BITS'(q_reg[NB]);
        quo = neg_reg[NB] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

endmodule

// File: design/box_ray_point_intersect.sv
// Top level of the box/segment/point intersection tester against a configured box.
//
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+-------------------------
//  request  | req_type, p_x..p_z, q_x..q_z              | start & !busy
//  result   | hit, unsupported                          | done, one cycle
//  config   | cfg_we, cfg_idx, cfg_data                 | cfg_we, no wait
//
// One beat enters per cycle; busy is tied low since the pipeline never stalls.
// The pipeline depth is set by the divider: one stage per quotient bit
// (32 bits) plus entry, subtract and combine stages.
// Reset clears the box registers to zero and all valid bits; payload is not reset.
// The receiver cannot stall, so results simply leave on done.
module box_ray_point_intersect
    import brpi_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   req_type,
    input  logic signed [COORD_BITS-1:0] p_x,
    input  logic signed [COORD_BITS-1:0] p_y,
    input  logic signed [COORD_BITS-1:0] p_z,
    input  logic signed [COORD_BITS-1:0] q_x,
    input  logic signed [COORD_BITS-1:0] q_y,
    input  logic signed [COORD_BITS-1:0] q_z,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_BITS-1:0]      cfg_idx,
    input  logic [COORD_BITS-1:0]        cfg_data,
    output logic                         done,
    output logic                         hit,
    output logic                         unsupported
);

    localparam int CW   = COORD_BITS;
    localparam int DW   = CW + 1;              // a difference fits in DW bits
    localparam int NB   = Q_INT + 1 + Q_FRAC;
    localparam int LAT  = NB + 3;              // s1 subtract, divider NB+1, combine

    logic signed [CW-1:0] lo_reg [3];
    logic signed [CW-1:0] hi_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int a = 0; a < 3; a++) begin
                lo_reg[a] <= '0;
                hi_reg[a] <= '0;
            end
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_LO_X: lo_reg[0] <= cfg_data;
                REG_LO_Y: lo_reg[1] <= cfg_data;
                REG_LO_Z: lo_reg[2] <= cfg_data;
                REG_HI_X: hi_reg[0] <= cfg_data;
                REG_HI_Y: hi_reg[1] <= cfg_data;
                REG_HI_Z: hi_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic accept;
    assign accept = start & ~busy;

    logic signed [CW-1:0] p_in [3];
    logic signed [CW-1:0] q_in [3];
    assign p_in = '{p_x, p_y, p_z};
    assign q_in = '{q_x, q_y, q_z};

    // Stage 1: differences, per-axis flags and the simple comparisons of box and point modes.
    logic signed [DW:0] num_lo_reg [3];
    logic signed [DW:0] num_hi_reg [3];
    logic signed [DW:0] den_reg    [3];
    axis_flags_t        flags_reg  [3];
    logic               ovl_reg;
    logic               pnt_reg;
    logic [1:0]         type1_reg;
    logic               v1_reg;

    always_ff @(posedge clk)
    begin
        logic ov, pt;
        ov = 1'b1;
        pt = 1'b1;
        for (int a = 0; a < 3; a++) begin
            num_lo_reg[a] <= (DW+1)'(lo_reg[a]) - (DW+1)'(p_in[a]);
            num_hi_reg[a] <= (DW+1)'(hi_reg[a]) - (DW+1)'(p_in[a]);
            den_reg[a]    <= (DW+1)'(q_in[a]) - (DW+1)'(p_in[a]);
            flags_reg[a].zero_dir <= q_in[a] == p_in[a];
            flags_reg[a].in_slab  <= p_in[a] >= lo_reg[a] && p_in[a] <= hi_reg[a];
            if (!(hi_reg[a] >= p_in[a] && q_in[a] >= lo_reg[a])) ov = 1'b0;
            if (!(p_in[a] <= hi_reg[a] && p_in[a] >= lo_reg[a])) pt = 1'b0;
        end
        ovl_reg   <= ov;
        pnt_reg   <= pt;
        type1_reg <= req_type;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v1_reg <= 1'b0;
        else        v1_reg <= accept;
    end

    // Divider bank: six units, one per slab bound.
    logic signed [T_BITS:0] t_lo [3];
    logic signed [T_BITS:0] t_hi [3];
    for (genvar a = 0; a < 3; a++) begin : g_axis
        brpi_slab_div #(.W(DW)) u_div_lo (
            .clk(clk),
            .num(num_lo_reg[a]), .den(den_reg[a]), .quo(t_lo[a]));
        brpi_slab_div #(.W(DW)) u_div_hi (
            .clk(clk),
            .num(num_hi_reg[a]), .den(den_reg[a]), .quo(t_hi[a]));
    end

    // Side pipeline carrying mode results alongside the divider.
    localparam int DD = NB + 1;
    axis_flags_t flg_d [0:DD][3];
    logic        ovl_d [0:DD];
    logic        pnt_d [0:DD];
    logic [1:0]  typ_d [0:DD];
    logic        v_d   [0:DD];

    assign flg_d[0] = flags_reg;
    assign ovl_d[0] = ovl_reg;
    assign pnt_d[0] = pnt_reg;
    assign typ_d[0] = type1_reg;
    assign v_d[0]   = v1_reg;

    for (genvar s = 0; s < DD; s++) begin : g_side
        always_ff @(posedge clk)
        begin
            flg_d[s+1] <= flg_d[s];
            ovl_d[s+1] <= ovl_d[s];
            pnt_d[s+1] <= pnt_d[s];
            typ_d[s+1] <= typ_d[s];
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) v_d[s+1] <= 1'b0;
            else        v_d[s+1] <= v_d[s];
        end
    end

    // Final stage: slab combine and mode selection.
    logic done_reg, hit_reg, uns_reg;
    logic seg_hit;

    always_comb
    begin
        logic signed [T_BITS:0] tmin, tmax, lo, hi;
        logic miss;
        tmin = -(T_BITS+1)'(33'sh7FFFFFFF);
        tmax =  (T_BITS+1)'(33'sh7FFFFFFF);
        miss = 1'b0;
        for (int a = 0; a < 3; a++) begin
            lo = (t_lo[a] < t_hi[a]) ? t_lo[a] : t_hi[a];
            hi = (t_lo[a] < t_hi[a]) ? t_hi[a] : t_lo[a];
            if (flg_d[DD][a].zero_dir) begin
                if (!flg_d[DD][a].in_slab) miss = 1'b1;
            end else begin
                if (lo > tmin) tmin = lo;
                if (hi < tmax) tmax = hi;
            end
        end
        seg_hit = !miss && tmax >= tmin && tmax >= 0
                  && tmin <= (T_BITS+1)'(1 << Q_FRAC);
    end

    always_ff @(posedge clk)
    begin
        uns_reg <= typ_d[DD] == REQ_RAYRAY;
        unique case (req_type_t'(typ_d[DD]))
            REQ_BOX:     hit_reg <= ovl_d[DD];
            REQ_SEGMENT: hit_reg <= seg_hit;
            REQ_POINT:   hit_reg <= pnt_d[DD];
            REQ_RAYRAY:  hit_reg <= 1'b0;
            default:     hit_reg <= 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) done_reg <= 1'b0;
        else        done_reg <= v_d[DD];
    end

    assign done        = done_reg;
    assign hit         = hit_reg;
    assign unsupported = uns_reg;

    // An unsupported result never reports a hit.
    a_uns_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(hit && unsupported)) else $error("hit with unsupported");
    // Every accepted beat yields a done.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LAT done) else $error("missing result");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LAT)) else $error("spurious result");

endmodule

// File: tb/tb.sv
// Self-checking testbench for the box, segment and point intersection tester.
`timescale 1ns / 1ps

module tb;
    import brpi_pkg::*;

    // The whole pipeline is 35 stages deep, so DRAIN_CYCLES covers it.
    localparam int DRAIN_CYCLES = 64;
    localparam longint T_LIMIT = 64'sd2147483647;
    localparam longint T_UNIT = 64'sd65536;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         req_type = REQ_BOX;
    logic signed [31:0] p_x = '0, p_y = '0, p_z = '0;
    logic signed [31:0] q_x = '0, q_y = '0, q_z = '0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_idx = REG_LO_X;
    logic [31:0]        cfg_data = '0;
    logic               done, hit, unsupported;

    // Our own copy of the reference box, kept in step with every register write.
    longint box_lo[3];
    longint box_hi[3];

    // Expected {hit, unsupported} pairs, oldest first.
    logic [1:0] verdict_q[$];
    int         error_count = 0;
    int         idle_pct = 0;

    box_ray_point_intersect i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type),
        .p_x(p_x), .p_y(p_y), .p_z(p_z), .q_x(q_x), .q_y(q_y), .q_z(q_z),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .done(done), .hit(hit), .unsupported(unsupported)
    );

    always #10 clk = ~clk;

    task automatic report_mismatch(input string what);
        error_count++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    // Slab parameter in Q15.16: magnitude truncated toward zero, saturated to
    // 2^31 - 1, with the sign put back at the end.
    function automatic longint slab_param(input longint num, input longint den);
        logic   neg;
        longint n, d, ip, r, mag;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        ip = n / d;
        r = n % d;
        if (ip >= 64'sd32768)
            mag = T_LIMIT;
        else
            mag = (ip << 16) | ((r << 16) / d);
        return neg ? -mag : mag;
    endfunction

    function automatic logic segment_meets_box(input longint p[3], input longint q[3]);
        longint tmin, tmax, d, ta, tb, lo, hi;
        tmin = -T_LIMIT;
        tmax = T_LIMIT;
        for (int a = 0; a < 3; a++)
        begin
            d = q[a] - p[a];
            if (d == 0)
            begin
                // A segment flat on this axis must already sit inside the slab.
                if (p[a] < box_lo[a] || p[a] > box_hi[a])
                    return 1'b0;
            end
            else
            begin
                ta = slab_param(box_lo[a] - p[a], d);
                tb = slab_param(box_hi[a] - p[a], d);
                lo = (ta < tb) ? ta : tb;
                hi = (ta < tb) ? tb : ta;
                if (lo > tmin) tmin = lo;
                if (hi < tmax) tmax = hi;
            end
        end
        return (tmax >= tmin) && (tmax >= 0) && (tmin <= T_UNIT);
    endfunction

    // Returns {hit, unsupported} for one request against the current box.
    function automatic logic [1:0] intersect_verdict(input req_type_t kind,
                                                     input longint p[3], input longint q[3]);
        logic meets;
        meets = 1'b1;
        case (kind)
            REQ_BOX:
                for (int a = 0; a < 3; a++)
                    if (!(box_hi[a] >= p[a] && q[a] >= box_lo[a]))
                        meets = 1'b0;
            REQ_SEGMENT:
                meets = segment_meets_box(p, q);
            REQ_POINT:
                for (int a = 0; a < 3; a++)
                    if (!(p[a] <= box_hi[a] && p[a] >= box_lo[a]))
                        meets = 1'b0;
            default:
                return 2'b01;
        endcase
        return {meets, 1'b0};
    endfunction

    // Every result beat is compared with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (verdict_q.size() == 0)
                report_mismatch("result beat with nothing expected");
            else
            begin
                logic [1:0] want;
                want = verdict_q.pop_front();
                if (hit !== want[1])
                    report_mismatch($sformatf("hit %b, expected %b", hit, want[1]));
                if (unsupported !== want[0])
                    report_mismatch($sformatf("unsupported %b, expected %b",
                                              unsupported, want[0]));
            end
        end
    end

    // Sends one request beat. Called at a rising edge; returns at the edge that
    // accepted it, leaving start high so that back-to-back beats follow without a gap.
    task automatic send_request(input req_type_t kind,
                                input logic signed [31:0] px, py, pz, qx, qy, qz);
        longint p[3], q[3];
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        start <= 1'b1;
        req_type <= kind;
        p_x <= px; p_y <= py; p_z <= pz;
        q_x <= qx; q_y <= qy; q_z <= qz;
        p = '{px, py, pz};
        q = '{qx, qy, qz};
        do @(posedge clk); while (busy);
        verdict_q.push_back(intersect_verdict(kind, p, q));
    endtask

    // Waits for the pipeline to drain so registers change only while idle.
    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (verdict_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_box(input logic signed [31:0] lx, ly, lz, hx, hy, hz);
        logic signed [31:0] vals[6];
        vals = '{lx, ly, lz, hx, hy, hz};
        drain();
        for (int i = 0; i < 6; i++)
        begin
            cfg_we <= 1'b1;
            cfg_idx <= i[2:0];
            cfg_data <= vals[i];
            @(posedge clk);
            if (i < 3) box_lo[i] = vals[i];
            else       box_hi[i - 3] = vals[i];
        end
        // Indexes past the last register must be ignored by the block.
        cfg_idx <= 3'd6;
        cfg_data <= $urandom;
        @(posedge clk);
        cfg_idx <= 3'd7;
        cfg_data <= $urandom;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Coordinate generator: mostly near the box bounds or centre so that the edges and
    // small segments get hit, with some full-range and extreme values.
    function automatic logic signed [31:0] pick_coord(input int axis);
        longint base;
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            2: base = box_lo[axis];
            3: base = box_hi[axis];
            default: base = (box_lo[axis] + box_hi[axis]) / 2;
        endcase
        return 32'(base + $signed($urandom_range(2000)) - 1000);
    endfunction

    task automatic random_item;
        req_type_t          kind;
        logic signed [31:0] px, py, pz, qx, qy, qz;
        kind = req_type_t'($urandom_range(9) < 8 ? $urandom_range(2) : 3);
        px = pick_coord(0); py = pick_coord(1); pz = pick_coord(2);
        qx = pick_coord(0); qy = pick_coord(1); qz = pick_coord(2);
        // Flatten a segment on some axes to reach the zero-direction rule.
        if ($urandom_range(3) == 0) qx = px;
        if ($urandom_range(3) == 0) qy = py;
        if ($urandom_range(7) == 0) qz = pz;
        send_request(kind, px, py, pz, qx, qy, qz);
    endtask

    // Box at reset is the single point at the origin.
    task automatic test_reset_box;
        send_request(REQ_POINT, 0, 0, 0, 0, 0, 0);
        send_request(REQ_POINT, 1, 0, 0, 0, 0, 0);
        send_request(REQ_BOX, -5, -5, -5, 5, 5, 5);
        send_request(REQ_SEGMENT, -65536, 0, 0, 65536, 0, 0);
    endtask

    task automatic test_directed;
        write_box(-32'sh10000, -32'sh10000, -32'sh10000,
                  32'sh10000, 32'sh10000, 32'sh10000);
        // Box overlap touching a face, an inverted other box taken as given, and a full-range box.
        send_request(REQ_BOX, 32'sh10000, 0, 0, 32'sh20000, 1, 1);
        send_request(REQ_BOX, 32'sh20000, 0, 0, 32'sh10001, 1, 1);
        send_request(REQ_BOX, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                     32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        // Segment through the box, one ending short of it, and one reversed.
        send_request(REQ_SEGMENT, -32'sh30000, 0, 0, 32'sh30000, 0, 0);
        send_request(REQ_SEGMENT, -32'sh30000, 0, 0, -32'sh20000, 0, 0);
        send_request(REQ_SEGMENT, 32'sh30000, 5, 5, -32'sh30000, -5, -5);
        // Degenerate segments, inside and outside.
        send_request(REQ_SEGMENT, 7, 7, 7, 7, 7, 7);
        send_request(REQ_SEGMENT, 32'sh20000, 0, 0, 32'sh20000, 0, 0);
        // Zero direction on one axis, outside the slab there.
        send_request(REQ_SEGMENT, -32'sh30000, 32'sh20000, 0, 32'sh30000, 32'sh20000, 0);
        // Extremes drive the quotient into saturation.
        send_request(REQ_SEGMENT, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                     32'sh80000001, 32'sh80000001, 32'sh80000001);
        send_request(REQ_SEGMENT, 32'sh80000000, 0, 0, 32'sh7fffffff, 1, 0);
        // Points on a corner and just outside a face; q ignored for points.
        send_request(REQ_POINT, 32'sh10000, 32'sh10000, -32'sh10000, 32'sh5555, 3, 2);
        send_request(REQ_POINT, 32'sh10001, 0, 0, 0, 0, 0);
        send_request(REQ_RAYRAY, 0, 0, 0, 1, 1, 1);
        send_request(REQ_RAYRAY, 32'sh80000000, 32'sh7fffffff, -1, -1, 32'sh7fffffff, 0);
        // Inverted reference box: points never meet it, but box overlaps and segments with direction can.
        write_box(32'sh10000, 0, 0, -32'sh10000, 32'sh10000, 32'sh10000);
        send_request(REQ_POINT, 0, 5, 5, 0, 0, 0);
        send_request(REQ_BOX, -32'sh20000, 0, 0, 32'sh20000, 32'sh10000, 32'sh10000);
        send_request(REQ_SEGMENT, -32'sh20000, 5, 5, 32'sh20000, 5, 5);
        send_request(REQ_SEGMENT, 0, 5, 5, 0, 6, 6);
    endtask

    task automatic test_random_phase(input int pct, input int count);
        idle_pct = pct;
        for (int i = 0; i < count; i++)
            random_item();
    endtask

    initial
    begin
        box_lo = '{0, 0, 0};
        box_hi = '{0, 0, 0};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_box();
        test_directed();

        // Full-range box, then phases with other box settings (one of them random) and some idling.
        write_box(32'sh80000000, 32'sh80000000, 32'sh80000000,
                  32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        test_random_phase(0, 150);
        write_box(-32'sh30000, -32'sh8000, 0, 32'sh28000, 32'sh4000, 32'sh100);
        test_random_phase(62, 250);
        write_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        test_random_phase(29, 200);
        write_box(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                  32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        test_random_phase(0, 100);
        write_box(-32'sh1234, -32'sh50000, 32'sh80000000, 32'sh4321, 32'sh50000, 32'sh10);
        test_random_phase(62, 200);
        write_box(32'sh80000000, -1, -32'sh20000, 32'sh80000000, 1, 32'sh20000);
        test_random_phase(29, 230);

        drain();
        if (error_count == 0)
            $display("box_ray_point_intersect verification clean");
        else
            $display("box_ray_point_intersect verification failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("box_ray_point_intersect verification failed");
        $finish;
    end

endmodule

// File: filelist.f
design/brpi_pkg.sv
design/brpi_slab_div.sv
design/box_ray_point_intersect.sv
tb/tb.sv
